// ----- hdl/nhia_pkg.sv -----
`default_nettype none

package nhia_pkg;

    // fixed field widths
    localparam int ADDR_W    = 32;
    localparam int IFACE_W   = 8;
    localparam int HOP_IDX_W = 6;

    // one route request
    typedef struct packed {
        logic [ADDR_W-1:0]  next_hop_ip;
        logic [IFACE_W-1:0] out_interface;
    } t_req;

    // one result
    typedef struct packed {
        logic [HOP_IDX_W-1:0] hop_index;
        logic                 directly_connected;
        logic                 newly_added;
        logic                 table_full;
    } t_res;

    // one stored table entry
    typedef struct packed {
        logic [IFACE_W-1:0] iface;
        logic [ADDR_W-1:0]  addr;
    } t_entry;

endpackage

`default_nettype wire

// ----- hdl/next_hop_index_assigner_core.sv -----
// next hop index assigner
// request channel (i_req_valid / o_req_ready, payload i_req) carries one route:
// its next hop address and outgoing interface. the result channel
// (o_res_valid / i_res_ready, payload o_res) returns one result per request.
// a zero next hop is reported as directly connected and leaves the table alone.
// otherwise one comparator walks the stored entries through the single read
// port of the table, one entry per cycle, oldest first. a hit returns the
// stored index; a miss appends the route at the next free index, or flags
// table_full when all TABLE_DEPTH entries are used.
// a route that is not directly connected takes longer, as its result waits for the
// one-entry-per-cycle scan of the table.
// one request is handled at a time; o_req_ready is low while it is worked on.
// a finished result sits in an output register; if the receiver stalls, the
// block holds the next result internally and waits, without losing any.
// reset (i_rst_n low, synchronous) empties the table and the output register.
`default_nettype none

module next_hop_index_assigner_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_ready,
    input  wire nhia_pkg::t_req i_req,
    output logic                o_res_valid,
    input  wire logic           i_res_ready,
    output nhia_pkg::t_res      o_res
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int EXT_W = IDX_W + nhia_pkg::HOP_IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state                      r_state, n_state;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [CNT_W-1:0]            r_ptr, n_ptr;
    logic [IDX_W-1:0]            r_cmp_idx, n_cmp_idx;
    logic                        r_cmp_valid, n_cmp_valid;
    logic [nhia_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [nhia_pkg::IFACE_W-1:0] r_iface, n_iface;
    nhia_pkg::t_res              r_res, n_res;
    logic                        r_out_valid, n_out_valid;
    nhia_pkg::t_res              r_out, n_out;

    logic                        w_wr_en;
    nhia_pkg::t_entry            w_wr_data;
    nhia_pkg::t_entry            w_rd_data;
    logic                        w_hit;
    logic                        w_slot_free;
    logic [EXT_W-1:0]            w_hit_ext;
    logic [EXT_W-1:0]            w_new_ext;

    // entry table
    nhia_table #(
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_idx  (r_count[IDX_W-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_idx  (r_ptr[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // shared comparator and index widening to the result field
    assign w_hit       = r_cmp_valid && (w_rd_data.addr == r_addr);
    assign w_hit_ext   = {{nhia_pkg::HOP_IDX_W{1'b0}}, r_cmp_idx};
    assign w_new_ext   = {{nhia_pkg::HOP_IDX_W{1'b0}}, r_count[IDX_W-1:0]};
    assign w_slot_free = !r_out_valid || i_res_ready;
    assign w_wr_data   = '{iface: r_iface, addr: r_addr};

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_valid = r_cmp_valid;
        n_addr      = r_addr;
        n_iface     = r_iface;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_wr_en     = 1'b0;

        // output register drains
        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_addr      = i_req.next_hop_ip;
                    n_iface     = i_req.out_interface;
                    n_ptr       = '0;
                    n_cmp_valid = 1'b0;
                    n_res       = '0;
                    if (i_req.next_hop_ip == '0) begin
                        n_res.directly_connected = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_res           = '0;
                    n_res.hop_index = w_hit_ext[nhia_pkg::HOP_IDX_W-1:0];
                    n_state         = S_FIN;
                end else if (r_ptr == r_count) begin
                    // all reads issued, wait for the last compare then decide
                    n_cmp_valid = 1'b0;
                    if (!r_cmp_valid) begin
                        n_res = '0;
                        if (r_count < CNT_W'(TABLE_DEPTH)) begin
                            w_wr_en           = 1'b1;
                            n_count           = r_count + 1'b1;
                            n_res.hop_index   = w_new_ext[nhia_pkg::HOP_IDX_W-1:0];
                            n_res.newly_added = 1'b1;
                        end else begin
                            n_res.table_full = 1'b1;
                        end
                        n_state = S_FIN;
                    end
                end else begin
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_ptr[IDX_W-1:0];
                    n_ptr       = r_ptr + 1'b1;
                end
            end
            S_FIN: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
        r_ptr     <= n_ptr;
        r_cmp_idx <= n_cmp_idx;
        r_addr    <= n_addr;
        r_iface   <= n_iface;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

// ----- hdl/nhia_table.sv -----
`default_nettype none

module nhia_table #(
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_idx,
    input  wire nhia_pkg::t_entry         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_idx,
    output nhia_pkg::t_entry              o_rd_data
);

    // next hop storage, one write and one registered read per cycle
    nhia_pkg::t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_idx];
    end

endmodule

`default_nettype wire

// ----- hdl/nhia_checker.sv -----
`default_nettype none

module nhia_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_req_valid,
    input wire logic           o_req_ready,
    input wire nhia_pkg::t_req i_req,
    input wire logic           o_res_valid,
    input wire logic           i_res_ready,
    input wire nhia_pkg::t_res o_res
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("result changed while stalled");

    // at most one outcome flag per result
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $onehot0({o_res.directly_connected, o_res.newly_added,
                                  o_res.table_full}))
        else $error("conflicting result flags");

    // directly connected and table full report index zero
    a_zero_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.directly_connected || o_res.table_full)
            |-> o_res.hop_index == '0)
        else $error("nonzero index on directly connected or full result");

    // the block is busy right after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while previous one in flight");

    // a directly connected request, taken while no result is valid, does not give its result at once
    a_direct_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready && (i_req.next_hop_ip == '0) && !o_res_valid
            |=> !o_res_valid)
        else $error("result appeared too early");

endmodule

bind next_hop_index_assigner_core nhia_checker u_nhia_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .i_req       (i_req),
    .o_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .o_res       (o_res)
);

`default_nettype wire

// ----- tb/next_hop_result_checker.sv -----
`default_nettype none

module next_hop_result_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    input  wire logic           i_req_ready,
    input  wire nhia_pkg::t_req i_req,
    input  wire logic           i_res_valid,
    input  wire logic           i_res_ready,
    input  wire nhia_pkg::t_res i_res,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int REPORT_LIMIT = 10;

    // shadow copy of the hop table, only addresses decide the outcome
    logic [nhia_pkg::ADDR_W-1:0]  shadow_addrs [TABLE_DEPTH];
    logic [nhia_pkg::IFACE_W-1:0] shadow_ifaces [TABLE_DEPTH];
    int unsigned                  shadow_entries = 0;

    // results owed by the block, oldest first
    nhia_pkg::t_res hop_results_due [$];
    nhia_pkg::t_res due_res;
    nhia_pkg::t_res owed_res;
    int             fail_count = 0;

    // look up or insert one route and return the result it must produce
    function automatic nhia_pkg::t_res predict_hop_result(input nhia_pkg::t_req route);
        nhia_pkg::t_res res;
        int unsigned    slot;
        bit             found;
        res   = '0;
        found = 1'b0;
        if (route.next_hop_ip == '0) begin
            res.directly_connected = 1'b1;
        end else begin
            for (slot = 0; slot < shadow_entries; slot++) begin
                if (!found && shadow_addrs[slot] == route.next_hop_ip) begin
                    res.hop_index = slot[nhia_pkg::HOP_IDX_W-1:0];
                    found         = 1'b1;
                end
            end
            if (!found) begin
                if (shadow_entries < TABLE_DEPTH) begin
                    res.hop_index                 = shadow_entries[nhia_pkg::HOP_IDX_W-1:0];
                    res.newly_added               = 1'b1;
                    shadow_addrs[shadow_entries]  = route.next_hop_ip;
                    shadow_ifaces[shadow_entries] = route.out_interface;
                    shadow_entries++;
                end else begin
                    res.table_full = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // count a failure, print only the first few
    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    // compare results, then queue the prediction for a new request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_entries = 0;
            hop_results_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (hop_results_due.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected result idx=%0d dc=%0b new=%0b full=%0b",
                        i_res.hop_index, i_res.directly_connected,
                        i_res.newly_added, i_res.table_full));
                end else begin
                    due_res = hop_results_due.pop_front();
                    if (due_res.hop_index !== i_res.hop_index
                        || due_res.directly_connected !== i_res.directly_connected
                        || due_res.newly_added !== i_res.newly_added
                        || due_res.table_full !== i_res.table_full) begin
                        note_failure($sformatf({
                            "expected idx=%0d dc=%0b new=%0b full=%0b, ",
                            "got idx=%0d dc=%0b new=%0b full=%0b"},
                            due_res.hop_index, due_res.directly_connected,
                            due_res.newly_added, due_res.table_full,
                            i_res.hop_index, i_res.directly_connected,
                            i_res.newly_added, i_res.table_full));
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                owed_res = predict_hop_result(i_req);
                hop_results_due.insert(hop_results_due.size(), owed_res);
            end
        end
        o_fail_count = fail_count;
        o_pending    = hop_results_due.size();
    end

endmodule

`default_nettype wire

// ----- tb/tb_next_hop_index_assigner_core.sv -----
`default_nettype none

module tb_next_hop_index_assigner_core;

    localparam int TABLE_DEPTH      = 64;
    localparam int ROUTES_PER_PHASE = 510;
    localparam int DRAIN_CYCLES     = 80;
    localparam int KNOWN_HOPS_MAX   = 200;
    localparam int RUN_LIMIT        = 8_000_000;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_req_valid;
    logic           o_req_ready;
    nhia_pkg::t_req i_req;
    logic           o_res_valid;
    logic           i_res_ready;
    nhia_pkg::t_res o_res;

    int fail_count;
    int pending;
    int req_idle_pct;
    int res_idle_pct;

    // addresses already offered, reused to produce hits and repeated drops
    logic [nhia_pkg::ADDR_W-1:0] known_hops [$];

    next_hop_index_assigner_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    next_hop_result_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_ready  (o_req_ready),
        .i_req        (i_req),
        .i_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // receiver stalls at random
    always @(negedge i_clk) begin
        i_res_ready <= ($urandom_range(0, 99) >= res_idle_pct);
    end

    // offer one route request and hold it until accepted
    task automatic send_route(input logic [nhia_pkg::ADDR_W-1:0]  ip,
                              input logic [nhia_pkg::IFACE_W-1:0] iface);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < req_idle_pct) begin
            i_req_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req_valid         <= 1'b1;
        i_req.next_hop_ip   <= ip;
        i_req.out_interface <= iface;
        forever begin
            @(posedge i_clk);
            if (o_req_ready) break;
        end
    endtask

    // hold off requests until every owed result has come back
    task automatic drain_routes();
        @(negedge i_clk);
        i_req_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // random routes: mostly known hops and fresh ones, some directly connected
    task automatic run_routes(input int count);
        int                           n;
        int                           pick;
        logic [31:0]                  rnd;
        logic [nhia_pkg::ADDR_W-1:0]  ip;
        logic [nhia_pkg::IFACE_W-1:0] iface;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                ip = '0;
            end else if (pick < 60 && known_hops.size() > 0) begin
                ip = known_hops[$urandom_range(0, known_hops.size() - 1)];
            end else begin
                ip = $urandom;
                if (known_hops.size() < KNOWN_HOPS_MAX) begin
                    known_hops.insert(known_hops.size(), ip);
                end
            end
            rnd   = $urandom;
            iface = rnd[nhia_pkg::IFACE_W-1:0];
            send_route(ip, iface);
        end
    endtask

    // run timeout
    initial begin
        #(RUN_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // stimulus and verdict
    initial begin
        i_rst_n      = 1'b0;
        i_req_valid  = 1'b0;
        i_req        = '0;
        req_idle_pct = 0;
        res_idle_pct = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero hop, extreme addresses and interfaces, hits and misses
        send_route(32'h0000_0000, 8'h00);
        send_route(32'h0000_0000, 8'hff);
        send_route(32'hffff_ffff, 8'h00);
        send_route(32'hffff_ffff, 8'hff);
        send_route(32'h0000_0001, 8'haa);
        send_route(32'h8000_0000, 8'h55);
        send_route(32'h0000_0001, 8'h00);
        send_route(32'h0000_0000, 8'h80);
        send_route(32'h7fff_ffff, 8'h01);
        send_route(32'hffff_ffff, 8'h01);
        send_route(32'h8000_0000, 8'hff);
        send_route(32'h0000_0000, 8'h7f);
        send_route(32'h7fff_fffe, 8'hfe);
        send_route(32'h7fff_ffff, 8'h7f);
        known_hops.insert(known_hops.size(), 32'hffff_ffff);
        known_hops.insert(known_hops.size(), 32'h0000_0001);
        known_hops.insert(known_hops.size(), 32'h8000_0000);
        known_hops.insert(known_hops.size(), 32'h7fff_ffff);
        known_hops.insert(known_hops.size(), 32'h7fff_fffe);
        drain_routes();

        // sender idles lightly, receiver heavily
        req_idle_pct = 13;
        res_idle_pct = 61;
        run_routes(ROUTES_PER_PHASE);
        drain_routes();

        // roles swapped
        req_idle_pct = 61;
        res_idle_pct = 13;
        run_routes(ROUTES_PER_PHASE);
        drain_routes();

        // full speed on both sides
        req_idle_pct = 0;
        res_idle_pct = 0;
        run_routes(ROUTES_PER_PHASE);
        drain_routes();

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/nhia_pkg.sv
hdl/nhia_table.sv
hdl/next_hop_index_assigner_core.sv
hdl/nhia_checker.sv
tb/next_hop_result_checker.sv
tb/tb_next_hop_index_assigner_core.sv
